>>> rtl/cddc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddc_pkg: shared types and constants of the calendar date counter
// Defines the action and status codes, the date record, the month-length rule
// and the sortable date index.
// ----------------------------------------------------------------------------
package cddc_pkg;

	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned INDEX_W = 21;

	// Last representable year, counted from 2001
	localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd4095;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_APR = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd5;
	localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd8;
	localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd10;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

	localparam logic [DAY_W-1:0] DAY_FIRST   = 5'd0;
	localparam logic [DAY_W-1:0] DAY_LAST_31 = 5'd30;
	localparam logic [DAY_W-1:0] DAY_LAST_30 = 5'd29;
	localparam logic [DAY_W-1:0] DAY_LAST_29 = 5'd28;
	localparam logic [DAY_W-1:0] DAY_LAST_28 = 5'd27;

	// Leap year: year count mod 4 equals 3
	localparam logic [1:0] LEAP_PHASE = 2'd3;

	typedef enum logic [1:0] {
		ACT_HOLD = 2'd0,
		ACT_NEXT = 2'd1,
		ACT_PREV = 2'd2,
		ACT_LOAD = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SATURATE = 2'd1,
		ST_REJECT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// Zero-based last day of a month in a given year
	function automatic logic [DAY_W-1:0] last_day(
		input logic [MONTH_W-1:0] month,
		input logic [YEAR_W-1:0]  year
	);
		logic [DAY_W-1:0] ld;
		if (month == MONTH_FEB) begin
			ld = (year[1:0] == LEAP_PHASE) ? DAY_LAST_29 : DAY_LAST_28;
		end else if (month == MONTH_APR || month == MONTH_JUN ||
		             month == MONTH_SEP || month == MONTH_NOV) begin
			ld = DAY_LAST_30;
		end else begin
			ld = DAY_LAST_31;
		end
		return ld;
	endfunction

	// day + 31*(month + 12*year), built from shifts and adds
	function automatic logic [INDEX_W-1:0] date_index_f(input date_t d);
		logic [15:0] mi;
		mi = 16'({d.year, 3'b000}) + 16'({d.year, 2'b00}) + 16'(d.month);
		return {mi, 5'b00000} - INDEX_W'(mi) + INDEX_W'(d.day);
	endfunction

endpackage

>>> rtl/cddc_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddc_cmd_if: command channel of the calendar date counter
// Valid/ready channel carrying one action and an optional date to load.
// ----------------------------------------------------------------------------
interface cddc_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     action;
	logic [cddc_pkg::YEAR_W-1:0]    load_year;
	logic [cddc_pkg::MONTH_W-1:0]   load_month;
	logic [cddc_pkg::DAY_W-1:0]     load_day;

	modport source (output valid, action, load_year, load_month, load_day, input ready);
	modport sink   (input valid, action, load_year, load_month, load_day, output ready);
endinterface

>>> rtl/cddc_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddc_res_if: result channel of the calendar date counter
// Valid/ready channel carrying the current date, its index and a status.
// ----------------------------------------------------------------------------
interface cddc_res_if;
	logic                           valid;
	logic                           ready;
	logic [cddc_pkg::YEAR_W-1:0]    year_out;
	logic [cddc_pkg::MONTH_W-1:0]   month_out;
	logic [cddc_pkg::DAY_W-1:0]     day_out;
	logic [cddc_pkg::INDEX_W-1:0]   date_index;
	logic [1:0]                     status;

	modport source (output valid, year_out, month_out, day_out, date_index, status,
	                input ready);
	modport sink   (input valid, year_out, month_out, day_out, date_index, status,
	                output ready);
endinterface

>>> rtl/calendar_date_up_down_counter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_up_down_counter_unit: calendar date up/down counter
// Keeps a date (year from 2001, zero-based month and day) and answers every
// command transaction with the updated date, its sortable index and a status.
// ----------------------------------------------------------------------------
// Usage: every command transaction (hold, next day, previous day, load)
// produces exactly one result transaction, in order. The block takes one
// command per clock cycle while results are taken; a taken command is held
// in the command register and is then written into the result register,
// which drives the result channel.
// The one-per-cycle rate is set by the date register: each command reads the
// date left by the previous one and writes the new date in the same cycle
// that its result is registered. When the result consumer stalls, the
// command register fills and then cmd.ready drops until a result is taken.
// After reset the date is January 1 of year 0 (2001). Next day from the last
// day of year 4095 and previous day from the first day of year 0 leave the
// date as it is with status saturated; a load with month above 11 or day
// above 30 leaves the date as it is with status rejected. A load of a day
// that the month lacks is kept; the next step forward from it starts the
// following month.
// ----------------------------------------------------------------------------
module calendar_date_up_down_counter_unit (
	input  logic        clk,
	input  logic        arst_n,
	cddc_cmd_if.sink    cmd,
	cddc_res_if.source  res
);

	// Command register
	logic              valid_s1;
	cddc_pkg::action_t action_s1;
	cddc_pkg::date_t   load_s1;

	// Result register
	logic              valid_s2;
	cddc_pkg::date_t   date_s2;
	logic [cddc_pkg::INDEX_W-1:0] index_s2;
	cddc_pkg::status_t status_s2;

	// Current date
	cddc_pkg::date_t   date_q;

	cddc_pkg::date_t   date_nxt;
	cddc_pkg::status_t status_nxt;
	logic              adv_s2;

	// Move the held command into the result register when that slot is free
	// or being drained this cycle.
	assign adv_s2    = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Capture the command payload on each taken transaction
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1     <= cddc_pkg::action_t'(cmd.action);
			load_s1.year  <= cmd.load_year;
			load_s1.month <= cmd.load_month;
			load_s1.day   <= cmd.load_day;
		end
	end

	cddc_step u_step (
		.cur    (date_q),
		.action (action_s1),
		.load   (load_s1),
		.nxt    (date_nxt),
		.status (status_nxt)
	);

	// Advance the date only when the command leaves the command register,
	// so a stalled command is applied exactly once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			date_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s2) begin
				date_q   <= date_nxt;
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			date_s2   <= date_nxt;
			index_s2  <= cddc_pkg::date_index_f(date_nxt);
			status_s2 <= status_nxt;
		end
	end

	assign res.valid      = valid_s2;
	assign res.year_out   = date_s2.year;
	assign res.month_out  = date_s2.month;
	assign res.day_out    = date_s2.day;
	assign res.date_index = index_s2;
	assign res.status     = status_s2;

endmodule

>>> rtl/cddc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddc_step: next-date logic
// Applies one action to the current date: hold, advance or step back a day
// with month and year carries, or load a checked date.
// ----------------------------------------------------------------------------
module cddc_step (
	input  cddc_pkg::date_t   cur,
	input  cddc_pkg::action_t action,
	input  cddc_pkg::date_t   load,
	output cddc_pkg::date_t   nxt,
	output cddc_pkg::status_t status
);

	logic [cddc_pkg::DAY_W-1:0]   cur_last;
	logic [cddc_pkg::MONTH_W-1:0] prev_month;

	assign cur_last   = cddc_pkg::last_day(cur.month, cur.year);
	assign prev_month = cur.month - cddc_pkg::MONTH_W'(1);

	always_comb begin
		nxt    = cur;
		status = cddc_pkg::ST_OK;
		case (action)
			cddc_pkg::ACT_HOLD: begin
				nxt = cur;
			end
			cddc_pkg::ACT_NEXT: begin
				if (cur.day >= cur_last) begin
					if (cur.month >= cddc_pkg::MONTH_DEC) begin
						if (cur.year >= cddc_pkg::YEAR_MAX) begin
							status = cddc_pkg::ST_SATURATE;
						end else begin
							nxt.year  = cur.year + cddc_pkg::YEAR_W'(1);
							nxt.month = cddc_pkg::MONTH_JAN;
							nxt.day   = cddc_pkg::DAY_FIRST;
						end
					end else begin
						nxt.month = cur.month + cddc_pkg::MONTH_W'(1);
						nxt.day   = cddc_pkg::DAY_FIRST;
					end
				end else begin
					nxt.day = cur.day + cddc_pkg::DAY_W'(1);
				end
			end
			cddc_pkg::ACT_PREV: begin
				if (cur.day != cddc_pkg::DAY_FIRST) begin
					nxt.day = cur.day - cddc_pkg::DAY_W'(1);
				end else if (cur.month == cddc_pkg::MONTH_JAN) begin
					if (cur.year == '0) begin
						status = cddc_pkg::ST_SATURATE;
					end else begin
						nxt.year  = cur.year - cddc_pkg::YEAR_W'(1);
						nxt.month = cddc_pkg::MONTH_DEC;
						nxt.day   = cddc_pkg::DAY_LAST_31;
					end
				end else begin
					nxt.month = prev_month;
					nxt.day   = cddc_pkg::last_day(prev_month, cur.year);
				end
			end
			cddc_pkg::ACT_LOAD: begin
				if (load.month > cddc_pkg::MONTH_DEC || load.day > cddc_pkg::DAY_LAST_31 ||
				    load.year > cddc_pkg::YEAR_MAX) begin
					status = cddc_pkg::ST_REJECT;
				end else begin
					nxt = load;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

>>> rtl/cddc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cddc_checker: port-level checks for the calendar date counter
// Watches the result channel for range, index consistency, status code and stall hold.
// ----------------------------------------------------------------------------
module cddc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [cddc_pkg::YEAR_W-1:0]  year_out,
	input logic [cddc_pkg::MONTH_W-1:0] month_out,
	input logic [cddc_pkg::DAY_W-1:0]   day_out,
	input logic [cddc_pkg::INDEX_W-1:0] date_index,
	input logic [1:0]                   status
);

	logic [cddc_pkg::INDEX_W-1:0] index_exp;

	assign index_exp = cddc_pkg::INDEX_W'(day_out) + cddc_pkg::INDEX_W'(31) *
		(cddc_pkg::INDEX_W'(month_out) + cddc_pkg::INDEX_W'(12) *
		 cddc_pkg::INDEX_W'(year_out));

	// Stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(year_out) &&
		$stable(month_out) && $stable(day_out) && $stable(status))
		else $error("result changed while stalled");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> month_out <= cddc_pkg::MONTH_DEC &&
		day_out <= cddc_pkg::DAY_LAST_31)
		else $error("date out of range");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> date_index == index_exp)
		else $error("date index does not match date");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> status == cddc_pkg::ST_OK || status == cddc_pkg::ST_SATURATE ||
		status == cddc_pkg::ST_REJECT)
		else $error("undefined status code");

endmodule

bind calendar_date_up_down_counter_unit cddc_checker u_cddc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.year_out   (res.year_out),
	.month_out  (res.month_out),
	.day_out    (res.day_out),
	.date_index (res.date_index),
	.status     (res.status)
);
